// ----- hdl/ldiv_pkg.sv -----
package ldiv_pkg;

    localparam int PORT_BITS = 32;

    localparam logic FUNC_SIGNED   = 1'b0;
    localparam logic FUNC_UNSIGNED = 1'b1;

    typedef struct packed {
        logic valid;
        logic sgn;
        logic q;
        logic m;
        logic t;
        logic dz;
    } ctl_t;

endpackage

// ----- hdl/ldiv_cell.sv -----
module ldiv_cell #(
    parameter int WORD_BITS   = 32,
    parameter bit SIGNED_STEP = 1'b0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ldiv_pkg::ctl_t       ctl_in,
    input  logic [WORD_BITS-1:0] rem_in,
    input  logic [WORD_BITS-1:0] num_hi_in,
    input  logic [WORD_BITS-1:0] num_lo_in,
    input  logic [WORD_BITS-1:0] divisor_in,
    input  logic [WORD_BITS-1:0] quo_in,
    output ldiv_pkg::ctl_t       ctl_out,
    output logic [WORD_BITS-1:0] rem_out,
    output logic [WORD_BITS-1:0] num_hi_out,
    output logic [WORD_BITS-1:0] num_lo_out,
    output logic [WORD_BITS-1:0] divisor_out,
    output logic [WORD_BITS-1:0] quo_out
);
    import ldiv_pkg::*;

    localparam int W = WORD_BITS;

    logic           valid_reg;
    ctl_t           ctl_reg;
    ctl_t           ctl_next;
    logic [W-1:0]   rem_reg;
    logic [W-1:0]   rem_next;
    logic [W-1:0]   num_hi_reg;
    logic [W-1:0]   num_hi_next;
    logic [W-1:0]   num_lo_reg;
    logic [W-1:0]   num_lo_next;
    logic [W-1:0]   divisor_reg;
    logic [W-1:0]   quo_reg;
    logic [W-1:0]   quo_next;

    logic           over;
    logic [W-1:0]   rem_shift;
    logic           do_sub;
    logic [W+1:0]   operand;
    logic [W+1:0]   res;
    logic           ge;
    logic           q_new;

    always_comb
    begin
        over      = rem_in[W-1] & ~ctl_in.sgn;
        rem_shift = {rem_in[W-2:0], num_hi_in[W-1]};
        do_sub    = ~ctl_in.sgn | (ctl_in.q == ctl_in.m);
        operand   = {1'b0, over, rem_shift};
        if (do_sub)
        begin
            res = operand - {2'b00, divisor_in};
        end
        else
        begin
            res = operand + {2'b00, divisor_in};
        end
        ge    = ~res[W+1];
        q_new = rem_in[W-1] ^ res[W] ^ ctl_in.m;

        ctl_next    = ctl_in;
        rem_next    = rem_in;
        num_hi_next = num_hi_in;
        num_lo_next = num_lo_in;
        quo_next    = quo_in;

        if (!ctl_in.sgn)
        begin
            rem_next    = ge ? res[W-1:0] : rem_shift;
            num_hi_next = {num_hi_in[W-2:0], num_lo_in[W-1]};
            num_lo_next = {num_lo_in[W-2:0], 1'b0};
            quo_next    = {quo_in[W-2:0], ge};
        end
        else if (SIGNED_STEP)
        begin
            rem_next    = res[W-1:0];
            num_hi_next = {num_hi_in[W-2:0], 1'b0};
            quo_next    = {quo_in[W-2:0], ctl_in.t};
            ctl_next.q  = q_new;
            ctl_next.t  = (q_new == ctl_in.m);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        ctl_reg     <= ctl_next;
        rem_reg     <= rem_next;
        num_hi_reg  <= num_hi_next;
        num_lo_reg  <= num_lo_next;
        divisor_reg <= divisor_in;
        quo_reg     <= quo_next;
    end

    always_comb
    begin
        ctl_out       = ctl_reg;
        ctl_out.valid = valid_reg;
    end

    assign rem_out     = rem_reg;
    assign num_hi_out  = num_hi_reg;
    assign num_lo_out  = num_lo_reg;
    assign divisor_out = divisor_reg;
    assign quo_out     = quo_reg;

endmodule

// ----- hdl/long_divide_64_by_32.sv -----
// Divider of a double-word dividend by a single-word divisor.
// Request: drive func, dividend_high, dividend_low and divisor with start high;
// the request is taken at any edge where start is high and busy is low. busy
// stays low, so a new request may enter on every cycle.
// func low runs the signed non-restoring step sequence with no remainder
// correction; func high gives the low word of the unsigned floor quotient.
// Result: quotient and divisor_zero show for exactly one cycle with done high,
// once the request has passed through every cell of the row, in
// request order. Throughput is one request per cycle.
// The latency is set by a row of 2*WORD_BITS cells, one quotient bit per cell.
// Unsigned requests use every cell; signed requests pass the first half
// untouched and step through the second half.
// The receiver cannot hold results off and nothing is buffered.
// Reset clears every cell's valid flag; requests in flight are dropped.
module long_divide_64_by_32 #(
    parameter int WORD_BITS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           func,
    input  logic [ldiv_pkg::PORT_BITS-1:0] dividend_low,
    input  logic [ldiv_pkg::PORT_BITS-1:0] dividend_high,
    input  logic [ldiv_pkg::PORT_BITS-1:0] divisor,
    output logic                           done,
    output logic [ldiv_pkg::PORT_BITS-1:0] quotient,
    output logic                           divisor_zero
);
    import ldiv_pkg::*;

    localparam int W      = WORD_BITS;
    localparam int STAGES = 2 * W;
    localparam logic [W-1:0] ALL_ONES = '1;

    ctl_t         ctl_c     [STAGES+1];
    logic [W-1:0] rem_c     [STAGES+1];
    logic [W-1:0] num_hi_c  [STAGES+1];
    logic [W-1:0] num_lo_c  [STAGES+1];
    logic [W-1:0] divisor_c [STAGES+1];
    logic [W-1:0] quo_c     [STAGES+1];

    logic [W-1:0] lo_w;
    logic [W-1:0] hi_w;
    logic [W-1:0] d_w;
    logic         is_signed;
    logic [W-1:0] quo_final;

    assign busy      = 1'b0;
    assign lo_w      = W'(dividend_low);
    assign hi_w      = W'(dividend_high);
    assign d_w       = W'(divisor);
    assign is_signed = (func == FUNC_SIGNED);

    always_comb
    begin
        ctl_c[0].valid = start & ~busy;
        ctl_c[0].sgn   = is_signed;
        ctl_c[0].q     = hi_w[W-1];
        ctl_c[0].m     = d_w[W-1];
        ctl_c[0].t     = hi_w[W-1] ^ d_w[W-1];
        ctl_c[0].dz    = (d_w == '0);
        rem_c[0]       = is_signed ? hi_w : '0;
        num_hi_c[0]    = is_signed ? lo_w : hi_w;
        num_lo_c[0]    = is_signed ? '0 : lo_w;
        divisor_c[0]   = d_w;
        quo_c[0]       = '0;
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_cell
        ldiv_cell #(
            .WORD_BITS   (W),
            .SIGNED_STEP (i >= W)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl_in      (ctl_c[i]),
            .rem_in      (rem_c[i]),
            .num_hi_in   (num_hi_c[i]),
            .num_lo_in   (num_lo_c[i]),
            .divisor_in  (divisor_c[i]),
            .quo_in      (quo_c[i]),
            .ctl_out     (ctl_c[i+1]),
            .rem_out     (rem_c[i+1]),
            .num_hi_out  (num_hi_c[i+1]),
            .num_lo_out  (num_lo_c[i+1]),
            .divisor_out (divisor_c[i+1]),
            .quo_out     (quo_c[i+1])
        );
    end

    always_comb
    begin
        if (ctl_c[STAGES].sgn)
        begin
            quo_final = {quo_c[STAGES][W-2:0], ctl_c[STAGES].t};
        end
        else
        begin
            quo_final = quo_c[STAGES];
        end
    end

    assign done         = ctl_c[STAGES].valid;
    assign quotient     = PORT_BITS'(quo_final);
    assign divisor_zero = ctl_c[STAGES].dz;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##STAGES done)
        else $error("request did not complete after the cell row");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, STAGES))
        else $error("result with no matching request");

    a_zero_unsigned: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !ctl_c[STAGES].sgn && divisor_zero) |-> (quo_final == ALL_ONES))
        else $error("unsigned divide by zero did not give all ones");

    a_divisor_carried: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (divisor_zero == (divisor_c[STAGES] == '0)))
        else $error("zero flag disagrees with carried divisor");

endmodule

// ----- sim/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ldiv_pkg::*;

    localparam int W          = PORT_BITS;
    localparam int LATENCY    = 2 * W;
    localparam int IDLE_LIMIT = 4000;
    localparam int RANDOM_REQUESTS = 830;

    typedef struct {
        logic         func;
        logic [W-1:0] lo;
        logic [W-1:0] hi;
        logic [W-1:0] d;
    } div_request_t;

    typedef struct {
        logic         func;
        logic [W-1:0] quo;
        logic         dz;
    } div_result_t;

    logic         clk           = 1'b0;
    logic         rst_n         = 1'b0;
    logic         start         = 1'b0;
    logic         busy;
    logic         func          = FUNC_UNSIGNED;
    logic [W-1:0] dividend_low  = '0;
    logic [W-1:0] dividend_high = '0;
    logic [W-1:0] divisor       = '0;
    logic         done;
    logic [W-1:0] quotient;
    logic         divisor_zero;

    div_request_t pending_q[$];
    div_result_t  expected_q[$];

    bit taken          = 1'b0;
    int idle_cycles    = 0;
    int gap_left       = 0;
    int issued         = 0;
    int total_requests = 0;
    int accepted_count = 0;
    int checked_count  = 0;
    int signed_count   = 0;
    int zero_count     = 0;
    int mismatch_count = 0;

    long_divide_64_by_32 uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .dividend_low  (dividend_low),
        .dividend_high (dividend_high),
        .divisor       (divisor),
        .done          (done),
        .quotient      (quotient),
        .divisor_zero  (divisor_zero)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic logic [W-1:0] nonrestoring_steps(input logic [W-1:0] hi_in,
                                                        input logic [W-1:0] lo_in,
                                                        input logic [W-1:0] dvs);
        logic [W-1:0] hi;
        logic [W-1:0] lo;
        logic [W-1:0] bits;
        logic [W-1:0] prev;
        logic         q;
        logic         m;
        logic         t;
        logic         oldq;
        logic         shin;
        logic         cy;
        hi   = hi_in;
        lo   = lo_in;
        q    = hi[W-1];
        m    = dvs[W-1];
        t    = q ^ m;
        bits = '0;
        for (int i = 0; i < W; i++)
        begin
            oldq = q;
            bits = {bits[W-2:0], t};
            shin = lo[W-1];
            lo   = {lo[W-2:0], 1'b0};
            q    = hi[W-1];
            hi   = {hi[W-2:0], shin};
            prev = hi;
            if (oldq == m)
            begin
                hi = hi - dvs;
                cy = hi > prev;
            end
            else
            begin
                hi = hi + dvs;
                cy = hi < prev;
            end
            q = q ^ cy ^ m;
            t = (q == m);
        end
        return {bits[W-2:0], t};
    endfunction

    function automatic div_result_t predict_division(input div_request_t rq);
        div_result_t  e;
        logic [2*W-1:0] full;
        e.func = rq.func;
        e.dz   = (rq.d == '0);
        if (rq.func == FUNC_SIGNED)
            e.quo = nonrestoring_steps(rq.hi, rq.lo, rq.d);
        else if (e.dz)
            e.quo = '1;
        else
        begin
            full  = {rq.hi, rq.lo} / {{W{1'b0}}, rq.d};
            e.quo = full[W-1:0];
        end
        return e;
    endfunction

    function automatic div_request_t random_request();
        div_request_t rq;
        logic [W-1:0] mag;
        rq.func = $urandom_range(0, 1) ? FUNC_UNSIGNED : FUNC_SIGNED;
        rq.lo   = $urandom;
        case ($urandom_range(0, 15))
            0:       rq.d = '0;
            1, 2:    rq.d = $urandom_range(1, 15);
            3:       rq.d = -$urandom_range(1, 15);
            4:       rq.d = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            5:       rq.d = '1;
            6:       rq.d = $urandom >> $urandom_range(0, 31);
            default: rq.d = $urandom;
        endcase
        case ($urandom_range(0, 9))
            0:       rq.hi = {W{rq.lo[W-1]}};
            1:       rq.hi = '0;
            2:       rq.hi = '1;
            3:       rq.hi = $urandom;
            default:
            begin
                if (rq.d == '0)
                    rq.hi = $urandom;
                else
                begin
                    mag = (rq.func == FUNC_SIGNED && rq.d[W-1]) ? -rq.d : rq.d;
                    mag = (mag == '0) ? '0 : W'($urandom) % mag;
                    if (rq.func == FUNC_SIGNED && $urandom_range(0, 1))
                        rq.hi = ~mag;
                    else
                        rq.hi = mag;
                end
            end
        endcase
        return rq;
    endfunction

    task automatic add_request(input logic f, input logic [W-1:0] hi,
                               input logic [W-1:0] lo, input logic [W-1:0] d);
        pending_q.push_back(div_request_t'{f, lo, hi, d});
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    // driver: hold a request until taken, then idle for the drawn gap
    always @(negedge clk)
    begin
        div_request_t rq;
        if (rst_n && (!start || taken))
        begin
            if (gap_left != 0)
            begin
                start <= 1'b0;
                gap_left--;
            end
            else if (pending_q.size() != 0)
            begin
                rq = pending_q.pop_front();
                func          <= rq.func;
                dividend_low  <= rq.lo;
                dividend_high <= rq.hi;
                divisor       <= rq.d;
                start         <= 1'b1;
                gap_left = ((issued / 40) % 3 == 2) ? 0 : $urandom_range(0, 9);
                issued++;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor: predict on each taken request, check each strobed result
    always @(posedge clk)
    begin
        div_result_t e;
        taken = rst_n && start && !busy;
        if (taken)
        begin
            expected_q.push_back(predict_division(
                div_request_t'{func, dividend_low, dividend_high, divisor}));
            accepted_count++;
        end
        if (rst_n && done === 1'b1)
        begin
            if (expected_q.size() == 0)
                report_mismatch("result with no request outstanding");
            else
            begin
                e = expected_q.pop_front();
                if (quotient !== e.quo)
                    report_mismatch($sformatf("quotient %h, expected %h (func %0b)",
                                              quotient, e.quo, e.func));
                if (divisor_zero !== e.dz)
                    report_mismatch($sformatf("divisor_zero %b, expected %b",
                                              divisor_zero, e.dz));
                checked_count++;
                if (e.func == FUNC_SIGNED)
                    signed_count++;
                if (e.dz)
                    zero_count++;
            end
        end
        if (taken || (rst_n && done === 1'b1))
            idle_cycles = 0;
        else
            idle_cycles++;
    end

    initial
    begin
        add_request(FUNC_UNSIGNED, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        add_request(FUNC_UNSIGNED, 32'hffff_ffff, 32'hffff_ffff, 32'h0000_0000);
        add_request(FUNC_UNSIGNED, 32'h0000_0000, 32'hffff_ffff, 32'h0000_0001);
        add_request(FUNC_UNSIGNED, 32'h0000_0000, 32'h0000_0064, 32'h0000_0007);
        add_request(FUNC_UNSIGNED, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        add_request(FUNC_UNSIGNED, 32'hffff_fffe, 32'hffff_ffff, 32'hffff_ffff);
        add_request(FUNC_UNSIGNED, 32'h0000_0001, 32'h0000_0000, 32'h0000_0001);
        add_request(FUNC_UNSIGNED, 32'h8000_0000, 32'h0000_0000, 32'h8000_0000);
        add_request(FUNC_SIGNED,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        add_request(FUNC_SIGNED,   32'hffff_ffff, 32'hffff_ffff, 32'h0000_0000);
        add_request(FUNC_SIGNED,   32'h0000_0000, 32'h0000_0064, 32'h0000_0007);
        add_request(FUNC_SIGNED,   32'hffff_ffff, 32'hffff_ff9c, 32'h0000_0007);
        add_request(FUNC_SIGNED,   32'h0000_0000, 32'h0000_0064, 32'hffff_fff9);
        add_request(FUNC_SIGNED,   32'hffff_ffff, 32'hffff_ff9c, 32'hffff_fff9);
        add_request(FUNC_SIGNED,   32'h8000_0000, 32'h0000_0000, 32'h0000_0001);
        add_request(FUNC_SIGNED,   32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        add_request(FUNC_SIGNED,   32'h0000_0000, 32'h8000_0000, 32'hffff_ffff);
        add_request(FUNC_SIGNED,   32'hffff_ffff, 32'h8000_0000, 32'hffff_ffff);
        add_request(FUNC_SIGNED,   32'hffff_ffff, 32'h8000_0000, 32'h0000_0001);
        add_request(FUNC_SIGNED,   32'h8000_0000, 32'h0000_0000, 32'h8000_0000);
        add_request(FUNC_SIGNED,   32'h7fff_ffff, 32'hffff_ffff, 32'h7fff_ffff);
        repeat (RANDOM_REQUESTS)
            pending_q.push_back(random_request());
        total_requests = pending_q.size();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (!(accepted_count == total_requests && expected_q.size() == 0)
               && idle_cycles < IDLE_LIMIT)
            @(negedge clk);

        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Watchdog expired: %0d of %0d requests taken, %0d results outstanding",
                     accepted_count, total_requests, expected_q.size());
            $display("== FAIL ==");
        end
        else
        begin
            repeat (LATENCY + 16) @(negedge clk);
            $display("Checked %0d quotients: %0d signed step runs, %0d unsigned, %0d by zero.",
                     checked_count, signed_count, checked_count - signed_count, zero_count);
            $display("Mismatches found: %0d", mismatch_count);
            if (mismatch_count == 0)
                $display("== PASS ==");
            else
                $display("== FAIL ==");
        end
        $finish;
    end

endmodule
